// ===== src/pcomp_pkg.sv =====
// Shared types and constants for the pressure/temperature compensation pipeline.
// Used by the top level and the pipelined divider; depends on nothing.
`default_nettype none
package pcomp_pkg;

	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 31;

	localparam logic [2:0] REG_CAL_T1    = 3'd0;
	localparam logic [2:0] REG_CAL_T2    = 3'd1;
	localparam logic [2:0] REG_CAL_T3    = 3'd2;
	localparam logic [2:0] REG_CAL_P1    = 3'd3;
	localparam logic [2:0] REG_CAL_P2_P3 = 3'd4;
	localparam logic [2:0] REG_CAL_P4_P5 = 3'd5;
	localparam logic [2:0] REG_CAL_P6_P7 = 3'd6;
	localparam logic [2:0] REG_CAL_P8_P9 = 3'd7;

	localparam logic signed [24:0] T_OFFSET = 25'sd128000;
	localparam logic [20:0]        P_BASE   = 21'd1048576;
	localparam logic [11:0]        P_SCALE  = 12'd3125;

	typedef struct packed {
		logic signed [23:0] fine;
		logic signed [19:0] centi;
		logic               neg;
		logic               dz;
	} pcomp_side_t;

endpackage
`default_nettype wire

// ===== src/pcomp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, unsigned magnitudes.
// Depends on pcomp_pkg for widths and the sideband type carried with each beat.
`default_nettype none
module pcomp_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [pcomp_pkg::DIV_NUM_W-1:0]  in_num,
	input  logic [pcomp_pkg::DIV_DEN_W-1:0]  in_den,
	input  pcomp_pkg::pcomp_side_t           in_side,
	output logic                             out_valid,
	output logic [pcomp_pkg::DIV_NUM_W-1:0]  out_quot,
	output pcomp_pkg::pcomp_side_t           out_side
);
	import pcomp_pkg::*;

	logic                 vld_s  [DIV_NUM_W];
	logic [DIV_NUM_W-1:0] num_s  [DIV_NUM_W];
	logic [DIV_DEN_W-1:0] rem_s  [DIV_NUM_W];
	logic [DIV_DEN_W-1:0] den_s  [DIV_NUM_W];
	pcomp_side_t          side_s [DIV_NUM_W];

	genvar k;
	for (k = 0; k < DIV_NUM_W; k++) begin : g_step
		logic                 vld_prev;
		logic [DIV_NUM_W-1:0] num_prev;
		logic [DIV_DEN_W-1:0] rem_prev;
		logic [DIV_DEN_W-1:0] den_prev;
		pcomp_side_t          side_prev;
		logic [DIV_DEN_W:0]   trial;
		logic [DIV_DEN_W:0]   diff;

		if (k == 0) begin : g_first
			assign vld_prev  = in_valid;
			assign num_prev  = in_num;
			assign rem_prev  = '0;
			assign den_prev  = in_den;
			assign side_prev = in_side;
		end else begin : g_next
			assign vld_prev  = vld_s[k-1];
			assign num_prev  = num_s[k-1];
			assign rem_prev  = rem_s[k-1];
			assign den_prev  = den_s[k-1];
			assign side_prev = side_s[k-1];
		end

		assign trial = {rem_prev, num_prev[DIV_NUM_W-1]};
		assign diff  = trial - {1'b0, den_prev};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_prev;
			end
		end

		always_ff @(posedge clk) begin
			num_s[k]  <= {num_prev[DIV_NUM_W-2:0], ~diff[DIV_DEN_W]};
			rem_s[k]  <= diff[DIV_DEN_W] ? trial[DIV_DEN_W-1:0] : diff[DIV_DEN_W-1:0];
			den_s[k]  <= den_prev;
			side_s[k] <= side_prev;
		end
	end

	assign out_valid = vld_s[DIV_NUM_W-1];
	assign out_quot  = num_s[DIV_NUM_W-1];
	assign out_side  = side_s[DIV_NUM_W-1];

endmodule
`default_nettype wire

// ===== src/pressure_temperature_compensation.sv =====
// Top level of the barometric compensation pipeline: APB calibration registers,
// temperature and pressure datapath stages. Depends on pcomp_pkg and pcomp_div.
//
// Usage:
//   Load the eight calibration registers over APB (byte address 4*i) while
//   no sample is in flight. Present raw_temperature and raw_pressure with
//   start high; busy is always low, so a beat is taken in every cycle that
//   start is high. Each beat returns one result, shown for one cycle
//   with done high: fine_temperature, temperature_centi, pressure_q24_8
//   and divide_by_zero.
//   Throughput is one beat per clock. The pipeline has 8 datapath stages, 64
//   stages of the bit-per-stage divider and 5 stages of final correction.
//   A zero pressure divisor gives pressure_q24_8 = 0 with divide_by_zero set;
//   the temperature outputs are still valid.
//   Results cannot be held off: done is a one-cycle strobe.
//   Reset clears the calibration registers and drops all beats in flight.
`default_nettype none
module pressure_temperature_compensation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [19:0]        raw_temperature,
	input  logic [19:0]        raw_pressure,
	output logic               done,
	output logic signed [31:0] fine_temperature,
	output logic signed [31:0] temperature_centi,
	output logic [31:0]        pressure_q24_8,
	output logic               divide_by_zero,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import pcomp_pkg::*;

	localparam int LATENCY = 8 + DIV_NUM_W + 5;

	logic [15:0] cal_t1_q, cal_t2_q, cal_t3_q, cal_p1_q;
	logic [31:0] cal_p2_p3_q, cal_p4_p5_q, cal_p6_p7_q, cal_p8_p9_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_t1_q    <= '0;
			cal_t2_q    <= '0;
			cal_t3_q    <= '0;
			cal_p1_q    <= '0;
			cal_p2_p3_q <= '0;
			cal_p4_p5_q <= '0;
			cal_p6_p7_q <= '0;
			cal_p8_p9_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_CAL_T1:    cal_t1_q    <= pwdata[15:0];
				REG_CAL_T2:    cal_t2_q    <= pwdata[15:0];
				REG_CAL_T3:    cal_t3_q    <= pwdata[15:0];
				REG_CAL_P1:    cal_p1_q    <= pwdata[15:0];
				REG_CAL_P2_P3: cal_p2_p3_q <= pwdata;
				REG_CAL_P4_P5: cal_p4_p5_q <= pwdata;
				REG_CAL_P6_P7: cal_p6_p7_q <= pwdata;
				REG_CAL_P8_P9: cal_p8_p9_q <= pwdata;
				default:       cal_t1_q    <= cal_t1_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_CAL_T1:    prdata = {16'b0, cal_t1_q};
			REG_CAL_T2:    prdata = {16'b0, cal_t2_q};
			REG_CAL_T3:    prdata = {16'b0, cal_t3_q};
			REG_CAL_P1:    prdata = {16'b0, cal_p1_q};
			REG_CAL_P2_P3: prdata = cal_p2_p3_q;
			REG_CAL_P4_P5: prdata = cal_p4_p5_q;
			REG_CAL_P6_P7: prdata = cal_p6_p7_q;
			REG_CAL_P8_P9: prdata = cal_p8_p9_q;
			default:       prdata = '0;
		endcase
	end

	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
	assign t2 = cal_t2_q;
	assign t3 = cal_t3_q;
	assign p2 = cal_p2_p3_q[15:0];
	assign p3 = cal_p2_p3_q[31:16];
	assign p4 = cal_p4_p5_q[15:0];
	assign p5 = cal_p4_p5_q[31:16];
	assign p6 = cal_p6_p7_q[15:0];
	assign p7 = cal_p6_p7_q[31:16];
	assign p8 = cal_p8_p9_q[15:0];
	assign p9 = cal_p8_p9_q[31:16];

	// stage 1: temperature products
	logic               vld_s1;
	logic signed [17:0] a_c;
	logic signed [16:0] b_c;
	logic signed [33:0] m1_c, bb_c, m1_s1, bb_s1;
	logic [19:0]        rp_s1;

	assign a_c  = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, cal_t1_q, 1'b0});
	assign b_c  = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, cal_t1_q});
	assign m1_c = a_c * t2;
	assign bb_c = b_c * b_c;

	// stage 2
	logic               vld_s2;
	logic signed [21:0] bbs_c;
	logic signed [37:0] m2_c, m2_s2;
	logic signed [22:0] v1_s2;
	logic [19:0]        rp_s2;

	assign bbs_c = bb_s1[33:12];
	assign m2_c  = bbs_c * t3;

	// stage 3: fine temperature
	logic               vld_s3;
	logic signed [23:0] tf_c, tf_s3;
	logic [19:0]        rp_s3;

	assign tf_c = 24'(v1_s2) + m2_s2[37:14];

	// stage 4: offset and first pressure products
	logic               vld_s4;
	logic signed [24:0] x_c;
	logic signed [49:0] xx_c, xx_s4;
	logic signed [40:0] xp5_c, xp2_c, xp5_s4, xp2_s4;
	logic signed [27:0] c5_c;
	pcomp_side_t        side_s4;
	logic [19:0]        rp_s4;

	assign x_c   = 25'(tf_s3) - T_OFFSET;
	assign xx_c  = x_c * x_c;
	assign xp5_c = x_c * p5;
	assign xp2_c = x_c * p2;
	assign c5_c  = 28'(tf_s3) * 28'sd5 + 28'sd128;

	// stage 5
	logic               vld_s5;
	logic signed [63:0] xxp6_c, xxp3_c, xxp6_s5, xxp3_s5;
	logic signed [40:0] xp5_s5, xp2_s5;
	pcomp_side_t        side_s5;
	logic [19:0]        rp_s5;

	assign xxp6_c = xx_s4 * p6;
	assign xxp3_c = xx_s4 * p3;

	// stage 6
	logic               vld_s6;
	logic signed [63:0] w_c, y_c;
	logic [63:0]        w_s6, y_s6;
	pcomp_side_t        side_s6;
	logic [19:0]        rp_s6;

	assign w_c = xxp6_s5 + (64'(xp5_s5) <<< 17) + (64'(p4) <<< 35);
	assign y_c = (xxp3_s5 >>> 8) + (64'(xp2_s5) <<< 12);

	// stage 7: divisor and dividend
	logic               vld_s7;
	logic [63:0]        yp_c, dp_c, n_c, n_s7;
	logic [20:0]        pdiff_c;
	logic signed [30:0] d_s7;
	pcomp_side_t        side_s7;

	assign yp_c    = y_s6 + 64'h0000_8000_0000_0000;
	assign dp_c    = yp_c * cal_p1_q;
	assign pdiff_c = P_BASE - {1'b0, rp_s6};
	assign n_c     = ({12'b0, pdiff_c, 31'b0} - w_s6) * P_SCALE;

	// stage 8: magnitudes
	logic                 vld_s8;
	logic [DIV_NUM_W-1:0] mag_n_s8;
	logic [DIV_DEN_W-1:0] mag_d_s8;
	pcomp_side_t          side_s8, side_c8;

	always_comb begin
		side_c8     = side_s7;
		side_c8.neg = n_s7[63] ^ d_s7[30];
		side_c8.dz  = (d_s7 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		m1_s1 <= m1_c;
		bb_s1 <= bb_c;
		rp_s1 <= raw_pressure;

		v1_s2 <= m1_s1[33:11];
		m2_s2 <= m2_c;
		rp_s2 <= rp_s1;

		tf_s3 <= tf_c;
		rp_s3 <= rp_s2;

		xx_s4         <= xx_c;
		xp5_s4        <= xp5_c;
		xp2_s4        <= xp2_c;
		side_s4.fine  <= tf_s3;
		side_s4.centi <= c5_c[27:8];
		side_s4.neg   <= 1'b0;
		side_s4.dz    <= 1'b0;
		rp_s4         <= rp_s3;

		xxp6_s5 <= xxp6_c;
		xxp3_s5 <= xxp3_c;
		xp5_s5  <= xp5_s4;
		xp2_s5  <= xp2_s4;
		side_s5 <= side_s4;
		rp_s5   <= rp_s4;

		w_s6    <= w_c;
		y_s6    <= y_c;
		side_s6 <= side_s5;
		rp_s6   <= rp_s5;

		d_s7    <= dp_c[63:33];
		n_s7    <= n_c;
		side_s7 <= side_s6;

		mag_n_s8 <= n_s7[63] ? (64'd0 - n_s7) : n_s7;
		mag_d_s8 <= d_s7[30] ? DIV_DEN_W'(-d_s7) : d_s7;
		side_s8  <= side_c8;
	end

	logic                 dv_valid;
	logic [DIV_NUM_W-1:0] dv_quot;
	pcomp_side_t          dv_side;

	pcomp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s8),
		.in_num    (mag_n_s8),
		.in_den    (mag_d_s8),
		.in_side   (side_s8),
		.out_valid (dv_valid),
		.out_quot  (dv_quot),
		.out_side  (dv_side)
	);

	// stage 9: signed quotient
	logic               vld_s9;
	logic signed [63:0] p_s9;
	pcomp_side_t        side_s9;

	// stage 10
	logic               vld_s10;
	logic signed [63:0] q_c, p8p_c, p_s10, p8p_s10;
	logic [63:0]        qlql_c, qlql_s10;
	logic [31:0]        qx_c, qx_s10;
	pcomp_side_t        side_s10;

	assign q_c    = p_s9 >>> 13;
	assign qlql_c = q_c[31:0] * q_c[31:0];
	assign qx_c   = q_c[31:0] * q_c[63:32];
	assign p8p_c  = p_s9 * p8;

	// stage 11
	logic               vld_s11;
	logic signed [63:0] qq_s11, c2_s11, p_s11;
	pcomp_side_t        side_s11;

	// stage 12
	logic               vld_s12;
	logic signed [63:0] p9qq_c, p9qq_s12, c2_s12, p_s12;
	pcomp_side_t        side_s12;

	assign p9qq_c = qq_s11 * p9;

	// stage 13: output register
	logic signed [63:0] sum_c;
	logic [31:0]        pres_c;

	assign sum_c  = p_s12 + (p9qq_s12 >>> 25) + c2_s12;
	assign pres_c = sum_c[39:8] + {{12{p7[15]}}, p7, 4'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			done    <= 1'b0;
		end else begin
			vld_s9  <= dv_valid;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			done    <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		p_s9    <= dv_side.neg ? (64'sd0 - $signed(dv_quot)) : $signed(dv_quot);
		side_s9 <= dv_side;

		p_s10    <= p_s9;
		qlql_s10 <= qlql_c;
		qx_s10   <= qx_c;
		p8p_s10  <= p8p_c;
		side_s10 <= side_s9;

		qq_s11   <= qlql_s10 + {qx_s10[30:0], 33'b0};
		c2_s11   <= p8p_s10 >>> 19;
		p_s11    <= p_s10;
		side_s11 <= side_s10;

		p9qq_s12 <= p9qq_c;
		c2_s12   <= c2_s11;
		p_s12    <= p_s11;
		side_s12 <= side_s11;

		fine_temperature  <= 32'(side_s12.fine);
		temperature_centi <= 32'(side_s12.centi);
		pressure_q24_8    <= side_s12.dz ? 32'd0 : pres_c;
		divide_by_zero    <= side_s12.dz;
	end

`ifndef ASSERT_OFF
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("beat accepted without a result after the pipeline latency");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && divide_by_zero |-> pressure_q24_8 == 32'd0)
		else $error("zero divisor with nonzero pressure");

	a_centi: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> temperature_centi == ((fine_temperature * 5 + 128) >>> 8))
		else $error("temperature out of step with fine temperature");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/pressure_temperature_compensation_tb.sv =====
// Testbench for the pressure/temperature compensation pipeline: loads calibration over APB,
// streams raw samples and checks every result against a behavioral predictor.
// Depends on pcomp_pkg and the pressure_temperature_compensation RTL.
`timescale 1ns / 1ps
module pressure_temperature_compensation_tb;
	import pcomp_pkg::*;

	typedef struct {
		logic signed [31:0] fine;
		logic signed [31:0] centi;
		logic [31:0]        pres;
		logic               dz;
	} comp_result_t;

	localparam int DRAIN_CYCLES = 120;
	localparam int WATCHDOG_LIMIT = 2000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [19:0]        raw_temperature = '0;
	logic [19:0]        raw_pressure = '0;
	logic               done;
	logic signed [31:0] fine_temperature;
	logic signed [31:0] temperature_centi;
	logic [31:0]        pressure_q24_8;
	logic               divide_by_zero;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	logic [15:0] cal_t1, cal_t2, cal_t3, cal_p1;
	logic [31:0] cal_p23, cal_p45, cal_p67, cal_p89;

	comp_result_t expected_results[$];
	int mismatches = 0;
	int beats_sent = 0;
	int results_seen = 0;
	int dz_seen = 0;
	int idle_cycles = 0;
	bit quiet_sender = 1'b0;

	always #1 clk = ~clk;

	pressure_temperature_compensation DUT (.*);

	function automatic logic [63:0] sx16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic logic [63:0] sra64(input logic [63:0] v, input int s);
		return $signed(v) >>> s;
	endfunction

	function automatic logic [63:0] sdiv(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] ma, mb, q;
		ma = a[63] ? -a : a;
		mb = b[63] ? -b : b;
		q = ma / mb;
		return (a[63] != b[63]) ? -q : q;
	endfunction

	function automatic comp_result_t compensate(input logic [19:0] adc_t, input logic [19:0] adc_p);
		comp_result_t r;
		logic [63:0] a, v1, b, v2, tf, x, w, y, d, p, q, c1, c2;
		a = {47'd0, adc_t[19:3]} - ({48'd0, cal_t1} << 1);
		v1 = sra64(a * sx16(cal_t2), 11);
		b = {48'd0, adc_t[19:4]} - {48'd0, cal_t1};
		v2 = sra64(sra64(b * b, 12) * sx16(cal_t3), 14);
		tf = v1 + v2;
		r.fine = tf[31:0];
		r.centi = 32'(sra64(tf * 5 + 128, 8));
		x = tf - 64'd128000;
		w = x * x * sx16(cal_p67[15:0]) + x * sx16(cal_p45[31:16]) * (64'd1 << 17)
			+ sx16(cal_p45[15:0]) * (64'd1 << 35);
		y = sra64(x * x * sx16(cal_p23[31:16]), 8) + x * sx16(cal_p23[15:0]) * 64'd4096;
		d = sra64(((64'd1 << 47) + y) * {48'd0, cal_p1}, 33);
		r.pres = '0;
		r.dz = (d == 0);
		if (!r.dz) begin
			p = 64'd1048576 - {44'd0, adc_p};
			p = sdiv(((p << 31) - w) * 64'd3125, d);
			q = sra64(p, 13);
			c1 = sra64(sx16(cal_p89[31:16]) * q * q, 25);
			c2 = sra64(sx16(cal_p89[15:0]) * p, 19);
			p = sra64(p + c1 + c2, 8) + sx16(cal_p67[31:16]) * 64'd16;
			r.pres = p[31:0];
		end
		return r;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		logic [31:0] rd_exp;
		rd_exp = (idx < REG_CAL_P2_P3) ? {16'd0, val[15:0]} : val;
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_CAL_T1: cal_t1 = val[15:0];
			REG_CAL_T2: cal_t2 = val[15:0];
			REG_CAL_T3: cal_t3 = val[15:0];
			REG_CAL_P1: cal_p1 = val[15:0];
			REG_CAL_P2_P3: cal_p23 = val;
			REG_CAL_P4_P5: cal_p45 = val;
			REG_CAL_P6_P7: cal_p67 = val;
			default: cal_p89 = val;
		endcase
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== rd_exp) begin
			mismatches++;
			if (mismatches <= 10)
				$display("register %0d read %h expected %h", idx, prdata, rd_exp);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_calibration(input logic [15:0] t1, t2, t3, p1,
			input logic [31:0] p23, p45, p67, p89);
		wait (expected_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(REG_CAL_T1, {16'hdead, t1});
		write_reg(REG_CAL_T2, {16'd0, t2});
		write_reg(REG_CAL_T3, {16'd0, t3});
		write_reg(REG_CAL_P1, {16'd0, p1});
		write_reg(REG_CAL_P2_P3, p23);
		write_reg(REG_CAL_P4_P5, p45);
		write_reg(REG_CAL_P6_P7, p67);
		write_reg(REG_CAL_P8_P9, p89);
	endtask

	// Send one beat; drop start only when the next beat is an idle.
	task automatic send_sample(input logic [19:0] t, input logic [19:0] p);
		if (!quiet_sender) begin
			while ($urandom_range(99) < 12) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		@(negedge clk);
		start <= 1'b1;
		raw_temperature <= t;
		raw_pressure <= p;
		do @(posedge clk); while (busy);
		expected_results.push_back(compensate(t, p));
		beats_sent++;
	endtask

	task automatic end_burst();
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic random_calibration();
		load_calibration(16'($urandom_range(26000, 30000)), 16'($urandom_range(25000, 28000)),
			16'($urandom_range(0, 100) - 50), 16'($urandom_range(34000, 38000)),
			{16'($urandom_range(0, 2000) - 1000), 16'($urandom_range(0, 20000) - 20000 + 16'd9000)},
			{16'($urandom_range(0, 400) - 200), 16'($urandom_range(2000, 9000))},
			{16'($urandom_range(0, 400) - 200), 16'($urandom_range(0, 20000) - 10000)},
			{16'($urandom_range(0, 30000)), 16'($urandom_range(0, 20000) - 10000)});
	endtask

	task automatic test_reset_calibration();
		// all-zero calibration: divisor is zero
		send_sample(20'd0, 20'd0);
		send_sample(20'hfffff, 20'hfffff);
		send_sample(20'h55555, 20'haaaaa);
		end_burst();
	endtask

	task automatic test_typical_sensor();
		load_calibration(16'd27504, 16'd26435, -16'sd1000, 16'd36477,
			{-16'sd10685 & 16'hffff, 16'd3024 ^ 16'hfc10}, {16'd140, 16'd2855},
			{16'd15500, -16'sd7 & 16'hffff}, {16'd6000, -16'sd14600 & 16'hffff});
		send_sample(20'd519888, 20'd415148);
		send_sample(20'd0, 20'd0);
		send_sample(20'hfffff, 20'hfffff);
		send_sample(20'hfffff, 20'd0);
		send_sample(20'd0, 20'hfffff);
		send_sample(20'h80000, 20'h80000);
		send_sample(20'h7ffff, 20'h00001);
		end_burst();
	endtask

	task automatic test_extreme_calibration();
		load_calibration(16'hffff, 16'h7fff, 16'h8000, 16'hffff,
			32'h8000_7fff, 32'h7fff_8000, 32'h8000_7fff, 32'h7fff_8000);
		send_sample(20'd0, 20'd0);
		send_sample(20'hfffff, 20'hfffff);
		send_sample(20'h12345, 20'hedcba);
		end_burst();
		load_calibration(16'h0000, 16'h8000, 16'h7fff, 16'h0001,
			32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_sample(20'd0, 20'hfffff);
		send_sample(20'hfffff, 20'd0);
		send_sample(20'haaaaa, 20'h55555);
		end_burst();
	endtask

	task automatic test_random_stream();
		for (int n = 0; n < 1200; n++) begin
			if (n % 300 == 0) begin
				end_burst();
				random_calibration();
			end
			quiet_sender = (n >= 600 && n < 800);
			if (n % 50 == 0)
				send_sample(20'($urandom_range(20'hfffff)), 20'($urandom_range(20'hfffff)));
			else
				send_sample(20'($urandom_range(380000, 640000)),
					20'($urandom_range(250000, 600000)));
			if (n == 400) begin
				end_burst();
				wait (expected_results.size() == 0);
			end
		end
		quiet_sender = 1'b0;
		end_burst();
		load_calibration(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			$urandom, $urandom, $urandom, $urandom);
		for (int n = 0; n < 100; n++)
			send_sample(20'($urandom_range(20'hfffff)), 20'($urandom_range(20'hfffff)));
		end_burst();
	endtask

	always @(posedge clk) begin
		comp_result_t e;
		if (arst_n && done) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat fine=%0d", fine_temperature);
			end else begin
				e = expected_results.pop_front();
				if (divide_by_zero)
					dz_seen++;
				if (fine_temperature !== e.fine || temperature_centi !== e.centi
						|| pressure_q24_8 !== e.pres || divide_by_zero !== e.dz) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: fine %0d/%0d centi %0d/%0d pres %h/%h dz %b/%b",
							e.fine, fine_temperature, e.centi, temperature_centi,
							e.pres, pressure_q24_8, e.dz, divide_by_zero);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || psel || expected_results.size() == 0 && !start)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results pending", expected_results.size());
			$display("pressure_temperature_compensation_tb failed");
			$finish;
		end
	end

	initial begin
		cal_t1 = '0; cal_t2 = '0; cal_t3 = '0; cal_p1 = '0;
		cal_p23 = '0; cal_p45 = '0; cal_p67 = '0; cal_p89 = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_calibration();
		test_typical_sensor();
		test_extreme_calibration();
		test_random_stream();
		wait (expected_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d beats, checked %0d results, %0d with zero divisor",
			beats_sent, results_seen, dz_seen);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("pressure_temperature_compensation_tb passed");
		else
			$display("pressure_temperature_compensation_tb failed");
		$finish;
	end
endmodule

// ===== pressure_temperature_compensation.f =====
src/pcomp_pkg.sv
src/pcomp_div.sv
src/pressure_temperature_compensation.sv
tb/sv/pressure_temperature_compensation_tb.sv
